### rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the SHA-1 hash engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed: consequent does not hold in the same cycle.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed: consequent does not hold in the next cycle.");

`endif

### rtl/core/sha1_pkg.sv
// Types and constants of the SHA-1 hash engine.
package sha1_pkg;

    typedef logic [31:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_LEN,
        ST_OUT
    } t_state;

    localparam int unsigned HashWords = 5;

    localparam t_word IV [HashWords] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam t_word K0 = 32'h5a827999;
    localparam t_word K1 = 32'h6ed9eba1;
    localparam t_word K2 = 32'h8f1bbcdc;
    localparam t_word K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET    = 6'd56;
    localparam logic [5:0] FILL_LAST     = 6'd63;
    localparam logic [6:0] ROUND_LAST    = 7'd79;
    localparam logic [2:0] LEN_LAST      = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

endpackage

### rtl/core/sha1_hash_engine_unit.sv
// SHA-1 hash engine: one message byte per transfer, digest as five words.
// A byte that does not complete a block is taken and ready stays high; a byte
// that completes a block loads the working registers from the chaining value,
// runs 80 rounds on one shared round unit, then the chaining add. An end
// transfer pads one byte per cycle outside its one or two compressions.
// Reset is synchronous and restores the initial chaining value, zero length.
`include "assert_macros.svh"

module sha1_hash_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_message_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_h0,
    output logic [31:0] o_digest_h1,
    output logic [31:0] o_digest_h2,
    output logic [31:0] o_digest_h3,
    output logic [31:0] o_digest_h4
);

    sha1_pkg::t_state r_state, n_state;
    sha1_pkg::t_state r_ret, n_ret;
    sha1_pkg::t_word  r_h [sha1_pkg::HashWords];
    sha1_pkg::t_word  n_h [sha1_pkg::HashWords];
    sha1_pkg::t_word  r_a, r_b, r_c, r_d, r_e;
    sha1_pkg::t_word  n_a, n_b, n_c, n_d, n_e;
    logic [511:0]     r_blk, n_blk;
    logic [5:0]       r_fill, n_fill;
    logic [63:0]      r_bits, n_bits;
    logic [6:0]       r_round, n_round;
    logic [2:0]       r_lcnt, n_lcnt;

    logic             push;
    logic [7:0]       push_byte;
    sha1_pkg::t_state push_after;
    sha1_pkg::t_word  w_cur, w_new, f_val, k_val, t_val;

    logic             in_round;
    logic             round_done;
    logic             restarted;

    assign o_ready     = (r_state == sha1_pkg::ST_IDLE);
    assign o_valid     = (r_state == sha1_pkg::ST_OUT);
    assign o_digest_h0 = r_h[0];
    assign o_digest_h1 = r_h[1];
    assign o_digest_h2 = r_h[2];
    assign o_digest_h3 = r_h[3];
    assign o_digest_h4 = r_h[4];

    // Message schedule window: the oldest word sits at the top of the buffer.
    assign w_cur = r_blk[511:480];
    always_comb begin
        logic [31:0] x;
        x     = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ w_cur;
        w_new = {x[30:0], x[31]};
    end

    always_comb begin
        case (r_round) inside
            [7'd0:7'd19]: begin
                f_val = (r_b & r_c) | (~r_b & r_d);
                k_val = sha1_pkg::K0;
            end
            [7'd20:7'd39]: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = sha1_pkg::K1;
            end
            [7'd40:7'd59]: begin
                f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                k_val = sha1_pkg::K2;
            end
            default: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = sha1_pkg::K3;
            end
        endcase
    end

    assign t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + w_cur;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_h        = r_h;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_d        = r_d;
        n_e        = r_e;
        n_blk      = r_blk;
        n_fill     = r_fill;
        n_bits     = r_bits;
        n_round    = r_round;
        n_lcnt     = r_lcnt;
        push       = 1'b0;
        push_byte  = 8'h00;
        push_after = r_state;

        case (r_state)
            sha1_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_byte_present) begin
                        push      = 1'b1;
                        push_byte = i_message_byte;
                        n_bits    = r_bits + sha1_pkg::BITS_PER_BYTE;
                    end
                    push_after = i_end_of_message ? sha1_pkg::ST_PAD_MARK : sha1_pkg::ST_IDLE;
                    n_state    = push_after;
                end
            end
            sha1_pkg::ST_ROUND: begin
                n_a     = t_val;
                n_b     = r_a;
                n_c     = {r_b[1:0], r_b[31:2]};
                n_d     = r_c;
                n_e     = r_d;
                n_blk   = {r_blk[479:0], w_new};
                n_round = r_round + 7'd1;
                if (r_round == sha1_pkg::ROUND_LAST) begin
                    n_state = sha1_pkg::ST_ADD;
                end
            end
            sha1_pkg::ST_ADD: begin
                n_h[0]  = r_h[0] + r_a;
                n_h[1]  = r_h[1] + r_b;
                n_h[2]  = r_h[2] + r_c;
                n_h[3]  = r_h[3] + r_d;
                n_h[4]  = r_h[4] + r_e;
                n_state = r_ret;
            end
            sha1_pkg::ST_PAD_MARK: begin
                push       = 1'b1;
                push_byte  = sha1_pkg::PAD_MARK_BYTE;
                push_after = sha1_pkg::ST_PAD_ZERO;
                n_state    = push_after;
            end
            sha1_pkg::ST_PAD_ZERO: begin
                if (r_fill == sha1_pkg::LEN_OFFSET) begin
                    n_state = sha1_pkg::ST_LEN;
                    n_lcnt  = 3'd0;
                end else begin
                    push       = 1'b1;
                    push_after = sha1_pkg::ST_PAD_ZERO;
                    n_state    = push_after;
                end
            end
            sha1_pkg::ST_LEN: begin
                push       = 1'b1;
                push_byte  = r_bits[63:56];
                n_bits     = {r_bits[55:0], 8'h00};
                n_lcnt     = r_lcnt + 3'd1;
                push_after = (r_lcnt == sha1_pkg::LEN_LAST) ? sha1_pkg::ST_OUT
                                                            : sha1_pkg::ST_LEN;
                n_state    = push_after;
            end
            sha1_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_h     = sha1_pkg::IV;
                    n_bits  = '0;
                    n_fill  = '0;
                    n_state = sha1_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sha1_pkg::ST_IDLE;
            end
        endcase

        // A byte enters the buffer; the last byte of a block starts a compression.
        if (push) begin
            n_blk  = {r_blk[503:0], push_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill == sha1_pkg::FILL_LAST) begin
                n_state = sha1_pkg::ST_ROUND;
                n_ret   = push_after;
                n_round = '0;
                n_a     = r_h[0];
                n_b     = r_h[1];
                n_c     = r_h[2];
                n_d     = r_h[3];
                n_e     = r_h[4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1_pkg::ST_IDLE;
            r_ret   <= sha1_pkg::ST_IDLE;
            r_h     <= sha1_pkg::IV;
            r_fill  <= '0;
            r_bits  <= '0;
            r_round <= '0;
            r_lcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_h     <= n_h;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_round <= n_round;
            r_lcnt  <= n_lcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
        r_blk <= n_blk;
    end

    assign in_round   = (r_state == sha1_pkg::ST_ROUND);
    assign round_done = in_round && (r_round == sha1_pkg::ROUND_LAST);
    assign restarted  = (r_h[0] == sha1_pkg::IV[0]) && (r_bits == 64'd0) && o_ready;

    `ASSERT_SAME(a_ready_excl_valid, i_clk, i_rst_n, o_valid, !o_ready)
    `ASSERT_SAME(a_round_empty_fill, i_clk, i_rst_n, in_round, r_fill == 6'd0)
    `ASSERT_NEXT(a_round_to_add, i_clk, i_rst_n, round_done, r_state == sha1_pkg::ST_ADD)
    `ASSERT_NEXT(a_restart_chain, i_clk, i_rst_n, o_valid && i_ready, restarted)

endmodule
